// ===== hw/rtl/bmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmcs_pkg
// Shared codes and constants for the brake motor current supervisor.
// ----------------------------------------------------------------------------
package bmcs_pkg;

    // Item action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_TIGHTEN = 2'd2;
    localparam logic [1:0] ACT_SERVICE = 2'd3;

    // Run modes (same encoding as the start actions)
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TIGHTEN = 2'd2;
    localparam logic [1:0] MODE_SERVICE = 2'd3;

    // Run status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TRIP    = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    // Final state codes
    localparam logic [1:0] FIN_RELEASED  = 2'd0;
    localparam logic [1:0] FIN_TIGHTENED = 2'd1;
    localparam logic [1:0] FIN_SERVICE   = 2'd2;
    localparam logic [1:0] FIN_ERROR     = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_REVUP_TICKS     = 3'd0;
    localparam logic [2:0] CFG_REVUP_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_RUN_LIMIT       = 3'd2;
    localparam logic [2:0] CFG_FREE_THRESH     = 3'd3;
    localparam logic [2:0] CFG_TIGHT_THRESH    = 3'd4;
    localparam logic [2:0] CFG_CONT_FREE       = 3'd5;
    localparam logic [2:0] CFG_CONT_TIGHT      = 3'd6;
    localparam logic [2:0] CFG_ANTILOCK_EN     = 3'd7;

    // Current rise above the free threshold that ends a service run, mA
    localparam logic [16:0] SERVICE_RISE_MA = 17'd2000;

    // Saturation value of the 16-bit timers
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Sample gap counter ceiling
    localparam logic [3:0] GAP_MAX = 4'd15;

endpackage

// ===== hw/rtl/brake_motor_current_supervisor.sv =====
// ----------------------------------------------------------------------------
// brake_motor_current_supervisor
// Per-tick supervisor for one parking-brake motor: run timers, current
// limits, overcurrent off time, free/tight detection and slip anti-lock.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one item per tick. action 1..3
//    starts a release, tighten or service run when idle; every other item
//    is a tick carrying current, sample flag, bridge fault and wheel speeds.
//  - Output channel (out_valid / out_stall): exactly one result per item,
//    carrying drive commands, busy, run_done with status and final state.
//  - Config port (cfg_we / cfg_index / cfg_data): register write, taken at
//    any edge with cfg_we high; write only while no item is in flight.
//  - Result timing: the result of an item is registered and presented in the cycle after its transfer.
//  - Throughput: one item per cycle while no held result is stalled. The
//    whole tick update is a handful of compares and adds from the state
//    registers to the result register.
//  - Stall: the result register holds while out_stall is high; in_stall is
//    raised only while a held result is stalled, so a taken result frees
//    the stage for a new item in the same cycle.
//  - Reset: run state goes idle, configuration takes its default values and
//    the output register empties.
// ----------------------------------------------------------------------------
module brake_motor_current_supervisor #(
    parameter int MAX_RUN_TICKS        = 20000,
    parameter int SERVICE_RUN_TICKS    = 50000,
    parameter int OFF_TICKS            = 5,
    parameter int SAMPLE_TIMEOUT_TICKS = 7
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] motor_current,
    input  logic        sample_valid,
    input  logic        bridge_fault,
    input  logic [7:0]  wheel_speed,
    input  logic [7:0]  average_speed,

    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        release_drive,
    output logic        tighten_drive,
    output logic        busy_res,
    output logic        run_done,
    output logic [1:0]  run_status,
    output logic [1:0]  final_state
);

    localparam logic [15:0] RUN_DEADLINE = 16'(MAX_RUN_TICKS);
    localparam logic [15:0] SVC_DEADLINE = 16'(SERVICE_RUN_TICKS);
    localparam logic [3:0]  OFF_LOAD     = 4'(OFF_TICKS);
    localparam logic [3:0]  GAP_LIMIT    = 4'(SAMPLE_TIMEOUT_TICKS);

    // configuration registers
    logic [15:0] revup_ticks_reg;
    logic [15:0] revup_limit_reg;
    logic [15:0] run_limit_reg;
    logic [15:0] free_thresh_reg;
    logic [15:0] tight_thresh_reg;
    logic [15:0] cont_free_reg;
    logic [15:0] cont_tight_reg;
    logic        antilock_en_reg;

    // run state
    logic [1:0]  mode_reg,     mode_next;
    logic [15:0] elapsed_reg,  elapsed_next;
    logic [15:0] deadline_reg, deadline_next;
    logic [3:0]  off_reg,      off_next;
    logic        reached_reg,  reached_next;
    logic [7:0]  lock_reg,     lock_next;
    logic [3:0]  gap_reg,      gap_next;
    logic        drv_rel_reg,  drv_rel_next;
    logic        drv_tgt_reg,  drv_tgt_next;

    // result register
    logic        out_valid_reg;
    logic        res_rel_reg,    res_rel_next;
    logic        res_tgt_reg,    res_tgt_next;
    logic        res_busy_reg,   res_busy_next;
    logic        res_done_reg,   res_done_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [1:0]  res_final_reg,  res_final_next;

    logic in_xfer;

    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revup_ticks_reg  <= 16'd2000;
            revup_limit_reg  <= 16'd8000;
            run_limit_reg    <= 16'd5000;
            free_thresh_reg  <= 16'd1000;
            tight_thresh_reg <= 16'd4000;
            cont_free_reg    <= 16'd1000;
            cont_tight_reg   <= 16'd1000;
            antilock_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmcs_pkg::CFG_REVUP_TICKS:  revup_ticks_reg  <= cfg_data;
                bmcs_pkg::CFG_REVUP_LIMIT:  revup_limit_reg  <= cfg_data;
                bmcs_pkg::CFG_RUN_LIMIT:    run_limit_reg    <= cfg_data;
                bmcs_pkg::CFG_FREE_THRESH:  free_thresh_reg  <= cfg_data;
                bmcs_pkg::CFG_TIGHT_THRESH: tight_thresh_reg <= cfg_data;
                bmcs_pkg::CFG_CONT_FREE:    cont_free_reg    <= cfg_data;
                bmcs_pkg::CFG_CONT_TIGHT:   cont_tight_reg   <= cfg_data;
                bmcs_pkg::CFG_ANTILOCK_EN:  antilock_en_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // tick update
    always_comb
    begin
        logic [16:0] el_sum;
        logic [16:0] dl_sum;
        logic [15:0] limit;
        logic [11:0] wheel_x4;
        logic [11:0] avg_x5;
        logic [11:0] avg_x10;
        logic [11:0] wheel_x9;
        logic        ended;
        logic [1:0]  end_status;
        logic        stop;
        logic        restored;

        mode_next     = mode_reg;
        elapsed_next  = elapsed_reg;
        deadline_next = deadline_reg;
        off_next      = off_reg;
        reached_next  = reached_reg;
        lock_next     = lock_reg;
        gap_next      = gap_reg;
        drv_rel_next  = drv_rel_reg;
        drv_tgt_next  = drv_tgt_reg;

        el_sum     = {1'b0, elapsed_reg} + 17'd1;
        dl_sum     = 17'd0;
        limit      = 16'd0;
        wheel_x4   = {2'b00, wheel_speed, 2'b00};
        avg_x5     = {4'b0000, average_speed} + {2'b00, average_speed, 2'b00};
        avg_x10    = {3'b000, average_speed, 1'b0} + {1'b0, average_speed, 3'b000};
        wheel_x9   = {4'b0000, wheel_speed} + {1'b0, wheel_speed, 3'b000};
        ended      = 1'b0;
        end_status = bmcs_pkg::STAT_OK;
        stop       = 1'b0;
        restored   = 1'b0;

        if (mode_reg == bmcs_pkg::MODE_IDLE)
        begin
            // start a run, or report an idle tick
            if (action != bmcs_pkg::ACT_TICK)
            begin
                mode_next     = action;
                elapsed_next  = 16'd0;
                deadline_next = (action == bmcs_pkg::ACT_SERVICE) ? SVC_DEADLINE
                                                                  : RUN_DEADLINE;
                off_next      = 4'd0;
                reached_next  = 1'b0;
                lock_next     = 8'd0;
                gap_next      = 4'd0;
                drv_rel_next  = (action != bmcs_pkg::ACT_TIGHTEN);
                drv_tgt_next  = (action == bmcs_pkg::ACT_TIGHTEN);
            end
        end
        else
        begin
            // saturating run timer and deadline
            elapsed_next = el_sum[16] ? bmcs_pkg::TICK_MAX : el_sum[15:0];
            if (elapsed_next >= deadline_reg)
            begin
                ended = 1'b1;
                stop  = 1'b1;
            end

            // sample watchdog for tighten and service
            if (!stop && mode_reg != bmcs_pkg::MODE_RELEASE)
            begin
                if (!sample_valid && !bridge_fault)
                begin
                    if (gap_reg < bmcs_pkg::GAP_MAX)
                        gap_next = gap_reg + 4'd1;
                    if (gap_next >= GAP_LIMIT)
                    begin
                        ended      = 1'b1;
                        end_status = bmcs_pkg::STAT_TIMEOUT;
                    end
                    stop = 1'b1;
                end
                else
                begin
                    gap_next = 4'd0;
                end
            end

            // bridge trip
            if (!stop && bridge_fault)
            begin
                ended      = 1'b1;
                end_status = bmcs_pkg::STAT_TRIP;
                stop       = 1'b1;
            end

            limit = (elapsed_next < revup_ticks_reg) ? revup_limit_reg : run_limit_reg;

            // slip anti-lock
            if (!stop && mode_reg == bmcs_pkg::MODE_TIGHTEN && antilock_en_reg)
            begin
                if (lock_next == 8'd0 && average_speed > 8'd1 && wheel_x4 < avg_x5)
                begin
                    lock_next    = wheel_speed;
                    drv_tgt_next = 1'b0;
                    drv_rel_next = 1'b1;
                end
                if (lock_next != 8'd0 && (avg_x10 > wheel_x9 || average_speed == 8'd0))
                begin
                    lock_next    = 8'd0;
                    drv_rel_next = 1'b0;
                    drv_tgt_next = 1'b1;
                end
            end

            // overcurrent cut and off-time countdown
            if (!stop)
            begin
                if (motor_current > limit)
                begin
                    if (mode_reg == bmcs_pkg::MODE_TIGHTEN)
                        drv_tgt_next = 1'b0;
                    else
                        drv_rel_next = 1'b0;
                    off_next = OFF_LOAD;
                    stop     = 1'b1;
                end
                else if (off_reg != 4'd0)
                begin
                    off_next = off_reg - 4'd1;
                    if (off_next == 4'd0)
                    begin
                        if (mode_reg == bmcs_pkg::MODE_TIGHTEN)
                            drv_tgt_next = 1'b1;
                        else
                            drv_rel_next = 1'b1;
                        restored = 1'b1;
                    end
                end
            end

            // free / tightened detection
            if (!stop && !restored && elapsed_next > revup_ticks_reg)
            begin
                case (mode_reg)
                    bmcs_pkg::MODE_RELEASE:
                    begin
                        if (!reached_reg && motor_current < free_thresh_reg)
                        begin
                            reached_next  = 1'b1;
                            dl_sum        = {1'b0, elapsed_next} + {1'b0, cont_free_reg};
                            deadline_next = dl_sum[16] ? bmcs_pkg::TICK_MAX : dl_sum[15:0];
                        end
                    end
                    bmcs_pkg::MODE_TIGHTEN:
                    begin
                        if (!reached_reg && motor_current > tight_thresh_reg)
                        begin
                            reached_next  = 1'b1;
                            dl_sum        = {1'b0, elapsed_next} + {1'b0, cont_tight_reg};
                            deadline_next = dl_sum[16] ? bmcs_pkg::TICK_MAX : dl_sum[15:0];
                        end
                    end
                    bmcs_pkg::MODE_SERVICE:
                    begin
                        if (!reached_reg && motor_current < free_thresh_reg)
                            reached_next = 1'b1;
                        else if (reached_reg && {1'b0, motor_current} >
                                 ({1'b0, free_thresh_reg} + bmcs_pkg::SERVICE_RISE_MA))
                            ended = 1'b1;
                    end
                    default: ;
                endcase
            end

            // run end
            if (ended)
            begin
                mode_next    = bmcs_pkg::MODE_IDLE;
                drv_rel_next = 1'b0;
                drv_tgt_next = 1'b0;
            end
        end

        // result fields
        res_rel_next    = drv_rel_next;
        res_tgt_next    = drv_tgt_next;
        res_busy_next   = (mode_next != bmcs_pkg::MODE_IDLE);
        res_done_next   = ended;
        res_status_next = ended ? end_status : bmcs_pkg::STAT_OK;
        if (!ended)
            res_final_next = bmcs_pkg::FIN_RELEASED;
        else if (end_status != bmcs_pkg::STAT_OK)
            res_final_next = bmcs_pkg::FIN_ERROR;
        else if (mode_reg == bmcs_pkg::MODE_RELEASE)
            res_final_next = bmcs_pkg::FIN_RELEASED;
        else if (mode_reg == bmcs_pkg::MODE_TIGHTEN)
            res_final_next = bmcs_pkg::FIN_TIGHTENED;
        else
            res_final_next = bmcs_pkg::FIN_SERVICE;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bmcs_pkg::MODE_IDLE;
            elapsed_reg  <= 16'd0;
            deadline_reg <= 16'd0;
            off_reg      <= 4'd0;
            reached_reg  <= 1'b0;
            lock_reg     <= 8'd0;
            gap_reg      <= 4'd0;
            drv_rel_reg  <= 1'b0;
            drv_tgt_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            mode_reg     <= mode_next;
            elapsed_reg  <= elapsed_next;
            deadline_reg <= deadline_next;
            off_reg      <= off_next;
            reached_reg  <= reached_next;
            lock_reg     <= lock_next;
            gap_reg      <= gap_next;
            drv_rel_reg  <= drv_rel_next;
            drv_tgt_reg  <= drv_tgt_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_rel_reg    <= res_rel_next;
            res_tgt_reg    <= res_tgt_next;
            res_busy_reg   <= res_busy_next;
            res_done_reg   <= res_done_next;
            res_status_reg <= res_status_next;
            res_final_reg  <= res_final_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign release_drive = res_rel_reg;
    assign tighten_drive = res_tgt_reg;
    assign busy_res      = res_busy_reg;
    assign run_done      = res_done_reg;
    assign run_status    = res_status_reg;
    assign final_state   = res_final_reg;

endmodule

// ===== hw/rtl/bmcs_checker.sv =====
// ----------------------------------------------------------------------------
// bmcs_checker
// Port-level checks for the brake motor current supervisor, bound to the
// top level.
// ----------------------------------------------------------------------------
module bmcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        release_drive,
    input logic        tighten_drive,
    input logic        busy_res,
    input logic        run_done,
    input logic [1:0]  run_status,
    input logic [1:0]  final_state
);

    // stalled result transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(run_done)
            && $stable(run_status) && $stable(final_state) && $stable(busy_res))
        else $error("stalled result changed");

    // end of run drops busy and both drives
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_done |-> !busy_res && !release_drive && !tighten_drive)
        else $error("run end with busy or drive set");

    // a failed run ends in the error state
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_done && run_status != bmcs_pkg::STAT_OK
            |-> final_state == bmcs_pkg::FIN_ERROR)
        else $error("failed run without error final state");

    // status and final state only on the ending result
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_done |-> run_status == bmcs_pkg::STAT_OK
            && final_state == bmcs_pkg::FIN_RELEASED)
        else $error("status reported without run end");

    // no drive while idle
    a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !release_drive && !tighten_drive)
        else $error("drive set while idle");

endmodule

bind brake_motor_current_supervisor bmcs_checker u_bmcs_checker (.*);
